// File: hw/rtl/sod_pkg.sv
// Shared constants, types and status structs for the point distance summing block.
package sod_pkg;

    // Coordinate and sum widths
    localparam int COORD_BITS = 16;
    localparam int SUM_BITS   = 32;
    localparam int BOUND_BITS = 32;
    localparam int AXES       = 3;

    // Radicand holds the sum of three squares of COORD_BITS-bit magnitudes
    localparam int RAD_BITS   = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS  = RAD_BITS / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_BITS);

    // Square pipeline sequencing: magnitude, square, accumulate, then report
    localparam int SQ_CNT_W   = $clog2(AXES + 3);

    typedef logic [COORD_BITS-1:0]            t_coord;
    typedef logic [AXES-1:0][COORD_BITS-1:0]  t_axes;
    typedef logic [RAD_BITS-1:0]              t_rad;
    typedef logic [ROOT_BITS-1:0]             t_root;
    typedef logic [SUM_BITS-1:0]              t_sum;
    typedef logic [BOUND_BITS-1:0]            t_bound;

    // Status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// File: hw/rtl/sod_ifs.sv
// Valid/ready channel interfaces for the point pair input and the distance result.
interface sod_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [sod_pkg::COORD_BITS-1:0] ax;
    logic signed [sod_pkg::COORD_BITS-1:0] ay;
    logic signed [sod_pkg::COORD_BITS-1:0] az;
    logic signed [sod_pkg::COORD_BITS-1:0] bx;
    logic signed [sod_pkg::COORD_BITS-1:0] by;
    logic signed [sod_pkg::COORD_BITS-1:0] bz;
    logic [sod_pkg::BOUND_BITS-1:0]        bound;
    logic                    use_bound;
    logic                    last;

    modport source (output valid, ax, ay, az, bx, by, bz, bound, use_bound, last,
                    input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, bound, use_bound, last,
                    output ready);
endinterface

interface sod_out_if;
    logic                          valid;
    logic                          ready;
    logic [sod_pkg::SUM_BITS-1:0]  distance;
    logic                          cut_short;

    modport source (output valid, distance, cut_short, input ready);
    modport sink   (input valid, distance, cut_short, output ready);
endinterface

// File: hw/rtl/sod_radicand.sv
// Squared distance builder: one shared multiplier squares the three axis differences in turn.
module sod_radicand (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sod_pkg::t_axes     i_a,
    input  sod_pkg::t_axes     i_b,
    output sod_pkg::t_unit_sts o_sts,
    output sod_pkg::t_rad      o_rad
);

    localparam int C = sod_pkg::COORD_BITS;
    localparam logic [sod_pkg::SQ_CNT_W-1:0] K_LAST_MAG  = sod_pkg::SQ_CNT_W'(sod_pkg::AXES - 1);
    localparam logic [sod_pkg::SQ_CNT_W-1:0] K_FIRST_MUL = sod_pkg::SQ_CNT_W'(1);
    localparam logic [sod_pkg::SQ_CNT_W-1:0] K_LAST_MUL  = sod_pkg::SQ_CNT_W'(sod_pkg::AXES);
    localparam logic [sod_pkg::SQ_CNT_W-1:0] K_FIRST_ACC = sod_pkg::SQ_CNT_W'(2);
    localparam logic [sod_pkg::SQ_CNT_W-1:0] K_DONE      = sod_pkg::SQ_CNT_W'(sod_pkg::AXES + 2);

    logic                          r_busy;
    logic [sod_pkg::SQ_CNT_W-1:0]  r_k;
    sod_pkg::t_axes                r_a;
    sod_pkg::t_axes                r_b;
    logic [C-1:0]                  r_mag;
    logic [2*C-1:0]                r_prod;
    sod_pkg::t_rad                 r_rad;

    logic signed [C:0]             w_diff;
    logic [C:0]                    w_neg;
    logic [C-1:0]                  w_mag;

    // Absolute difference of the axis at the head of the shift line
    always_comb begin
        w_diff = $signed({r_a[0][C-1], r_a[0]}) - $signed({r_b[0][C-1], r_b[0]});
        w_neg  = (C+1)'(-w_diff);
        w_mag  = w_diff[C] ? w_neg[C-1:0] : w_diff[C-1:0];
    end

    // Advance the magnitude, square and accumulate stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= '0;
            r_a    <= i_a;
            r_b    <= i_b;
            r_rad  <= '0;
        end else if (r_busy) begin
            if (r_k <= K_LAST_MAG) begin
                r_mag <= w_mag;
                for (int i = 0; i < sod_pkg::AXES - 1; i++) begin
                    r_a[i] <= r_a[i+1];
                    r_b[i] <= r_b[i+1];
                end
            end
            if (r_k >= K_FIRST_MUL && r_k <= K_LAST_MUL) begin
                r_prod <= r_mag * r_mag;
            end
            if (r_k >= K_FIRST_ACC && r_k < K_DONE) begin
                r_rad <= r_rad + sod_pkg::RAD_BITS'(r_prod);
            end
            if (r_k == K_DONE) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_k == K_DONE);
    assign o_rad      = r_rad;

endmodule

// File: hw/rtl/sod_isqrt.sv
// Bit-serial floor square root: one result bit per cycle by restoring trial subtraction.
module sod_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sod_pkg::t_rad      i_rad,
    output sod_pkg::t_unit_sts o_sts,
    output sod_pkg::t_root     o_root
);

    localparam int N     = sod_pkg::ROOT_BITS;
    localparam int REM_W = N + 2;

    logic                            r_busy;
    logic                            r_done;
    logic [sod_pkg::ROOT_CNT_W-1:0]  r_cnt;
    sod_pkg::t_rad                   r_rad;
    logic [REM_W-1:0]                r_rem;
    sod_pkg::t_root                  r_res;

    logic [REM_W+1:0]                w_shift;
    logic [REM_W+1:0]                w_trial;
    logic [REM_W+1:0]                w_sub;
    logic                            w_ge;

    // Bring down the next two radicand bits and try the subtraction
    always_comb begin
        w_shift = {r_rem, r_rad[sod_pkg::RAD_BITS-1 -: 2]};
        w_trial = (REM_W+2)'({r_res, 2'b01});
        w_ge    = (w_shift >= w_trial);
        w_sub   = w_shift - w_trial;
    end

    // Iterate one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sod_pkg::ROOT_CNT_W'(N - 1);
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_res  <= '0;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                r_rem <= w_ge ? w_sub[REM_W-1:0] : w_shift[REM_W-1:0];
                r_res <= {r_res[N-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_res;

endmodule

// File: hw/rtl/sum_of_3d_point_distances.sv
// Top level: sequencer, saturating accumulator, early exit and result register.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------
//  i_in     | in  | ax ay az bx by bz (16b signed), bound, use_bound, last
//  o_out    | out | distance (32b saturating sum), cut_short
//
// An item that is summed is accepted, passes the shared square/accumulate pipeline and the
// bit-serial square root, and is then added to the running sum and tested against the bound.
// An item that arrives while skipping the rest of a cut-short sequence is accepted and dropped.
// Reset clears the running sum and the skip flag. A result waits in the output
// register; the next item is accepted meanwhile, and only a second result stalls.
module sum_of_3d_point_distances (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sod_in_if.sink     i_in,
    sod_out_if.source  o_out
);

    localparam int ADD_W = ((sod_pkg::SUM_BITS > sod_pkg::ROOT_BITS) ?
                            sod_pkg::SUM_BITS : sod_pkg::ROOT_BITS) + 1;
    localparam int CMP_W = (sod_pkg::SUM_BITS > sod_pkg::BOUND_BITS) ?
                           sod_pkg::SUM_BITS : sod_pkg::BOUND_BITS;
    localparam logic [ADD_W-1:0] SUM_MAX = ADD_W'({sod_pkg::SUM_BITS{1'b1}});

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_ADD,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic                r_skip;
    sod_pkg::t_sum       r_sum;
    sod_pkg::t_bound     r_bound;
    logic                r_use;
    logic                r_last;
    logic                r_out_valid;
    sod_pkg::t_sum       r_out_dist;
    logic                r_out_cut;

    sod_pkg::t_unit_sts  w_rad_sts;
    sod_pkg::t_unit_sts  w_root_sts;
    sod_pkg::t_rad       w_rad;
    sod_pkg::t_root      w_root;
    sod_pkg::t_axes      w_a;
    sod_pkg::t_axes      w_b;
    logic                w_accept;
    logic                w_rad_start;
    logic                w_root_start;
    logic [ADD_W-1:0]    w_add;
    sod_pkg::t_sum       w_sat;
    logic                w_over;
    logic                w_out_free;
    logic                w_emit;

    // Decode the handshake and unit starts
    always_comb begin
        w_a          = {i_in.az, i_in.ay, i_in.ax};
        w_b          = {i_in.bz, i_in.by, i_in.bx};
        w_accept     = i_in.valid && i_in.ready;
        w_rad_start  = w_accept && !r_skip;
        w_root_start = (r_state == S_SQ) && w_rad_sts.done;
        w_add        = ADD_W'(r_sum) + ADD_W'(w_root);
        w_sat        = (w_add > SUM_MAX) ? {sod_pkg::SUM_BITS{1'b1}} :
                                           w_add[sod_pkg::SUM_BITS-1:0];
        w_over       = r_use && (CMP_W'(r_sum) > CMP_W'(r_bound));
        w_out_free   = !r_out_valid || o_out.ready;
        w_emit       = (r_state == S_EMIT) && (w_over || r_last) && w_out_free;
    end

    sod_radicand u_radicand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rad_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_sts   (w_rad_sts),
        .o_rad   (w_rad)
    );

    sod_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_rad   (w_rad),
        .o_sts   (w_root_sts),
        .o_root  (w_root)
    );

    // Hold state, running sum, skip flag and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_skip      <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_bound <= i_in.bound;
                        r_use   <= i_in.use_bound;
                        r_last  <= i_in.last;
                        if (r_skip) begin
                            // drop the item, leave skip mode at the end of the sequence
                            if (i_in.last) begin
                                r_skip <= 1'b0;
                            end
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    if (w_rad_sts.done) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_root_sts.done) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_sum   <= w_sat;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_over || r_last) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_dist  <= r_sum;
                            r_out_cut   <= w_over;
                            r_sum       <= '0;
                            r_skip      <= w_over && !r_last;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.distance  = r_out_dist;
    assign o_out.cut_short = r_out_cut;

`ifndef SYNTH
    // The radicand unit reports only while the sequencer waits for it
    a_rad_done_in_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rad_sts.done |-> (r_state == S_SQ))
        else $error("radicand done outside square phase");

    // Skip mode never overlaps work in the arithmetic units
    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_state == S_IDLE) && !w_rad_sts.busy && !w_root_sts.busy)
        else $error("arithmetic active while skipping");

    // A dropped item starts no arithmetic
    a_skip_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_skip) |=> (r_state == S_IDLE) && !w_rad_sts.busy)
        else $error("skipped item was processed");

    // An early exit is flagged on the delivered result
    a_cut_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_over) |=> o_out.valid && o_out.cut_short)
        else $error("early exit not flagged");
`endif

endmodule

// File: dv/sod_distance_check.sv
// Watches both channels, predicts each distance sum and compares it with what the block gives.
`timescale 1ns / 100ps

module sod_distance_check (
    input  logic i_clk,
    input  logic i_rst_n,
    sod_in_if    i_in_mon,
    sod_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        sod_pkg::t_sum distance;
        logic          cut_short;
    } t_sum_result;

    // Sums still owed by the block, oldest first
    t_sum_result expected_sums[$];

    // Predicted block state
    sod_pkg::t_sum acc_sum;
    bit            skip_rest;
    int            mismatches;

    // Square of one axis difference; the difference needs one bit more than a coordinate
    function automatic sod_pkg::t_rad axis_square(sod_pkg::t_coord a, sod_pkg::t_coord b);
        logic [sod_pkg::COORD_BITS:0] diff;
        logic [sod_pkg::COORD_BITS:0] mag;
        diff = {a[sod_pkg::COORD_BITS-1], a} - {b[sod_pkg::COORD_BITS-1], b};
        mag  = diff[sod_pkg::COORD_BITS] ? -diff : diff;
        return sod_pkg::t_rad'(mag) * sod_pkg::t_rad'(mag);
    endfunction

    // Floor square root, two radicand bits per step from the top
    function automatic sod_pkg::t_root floor_root(sod_pkg::t_rad rad);
        logic [sod_pkg::RAD_BITS+1:0] rem;
        logic [sod_pkg::RAD_BITS+1:0] trial;
        logic [sod_pkg::RAD_BITS+1:0] root;
        rem  = '0;
        root = '0;
        for (int p = sod_pkg::ROOT_BITS - 1; p >= 0; p--) begin
            rem   = (rem << 2) | (sod_pkg::RAD_BITS+2)'(rad[2*p +: 2]);
            trial = (root << 2) | (sod_pkg::RAD_BITS+2)'(1);
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | (sod_pkg::RAD_BITS+2)'(1);
            end else begin
                root = root << 1;
            end
        end
        return sod_pkg::t_root'(root);
    endfunction

    // Advance the predicted state by one accepted item; queue a sum if one is due
    task automatic absorb_pair();
        sod_pkg::t_rad              rad;
        sod_pkg::t_root             pair_len;
        logic [sod_pkg::SUM_BITS:0] wide;
        bit                         over;
        t_sum_result                res;
        if (skip_rest) begin
            if (i_in_mon.last) skip_rest = 1'b0;
            return;
        end
        rad  = axis_square(i_in_mon.ax, i_in_mon.bx)
             + axis_square(i_in_mon.ay, i_in_mon.by)
             + axis_square(i_in_mon.az, i_in_mon.bz);
        pair_len = floor_root(rad);
        wide = {1'b0, acc_sum} + (sod_pkg::SUM_BITS+1)'(pair_len);
        acc_sum = wide[sod_pkg::SUM_BITS] ? {sod_pkg::SUM_BITS{1'b1}}
                                          : wide[sod_pkg::SUM_BITS-1:0];
        over = i_in_mon.use_bound && (acc_sum > sod_pkg::t_sum'(i_in_mon.bound));
        if (over || i_in_mon.last) begin
            res.distance  = acc_sum;
            res.cut_short = over;
            expected_sums.push_back(res);
            acc_sum   = '0;
            skip_rest = over && !i_in_mon.last;
        end
    endtask

    always @(posedge i_clk) begin
        t_sum_result want;
        if (!i_rst_n) begin
            acc_sum   = '0;
            skip_rest = 1'b0;
            expected_sums.delete();
        end else begin
            // Check results before predicting, so a sum never meets its own item's expectation
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got distance=%0d cut_short=%0b",
                             $time, i_out_mon.distance, i_out_mon.cut_short);
                    mismatches++;
                end else begin
                    want = expected_sums.pop_front();
                    if (i_out_mon.distance !== want.distance) begin
                        $display("%0t: distance mismatch, expected %0d, got %0d",
                                 $time, want.distance, i_out_mon.distance);
                        mismatches++;
                    end
                    if (i_out_mon.cut_short !== want.cut_short) begin
                        $display("%0t: cut_short mismatch, expected %0b, got %0b",
                                 $time, want.cut_short, i_out_mon.cut_short);
                        mismatches++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) absorb_pair();
        end
        o_pending    <= expected_sums.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: dv/testbench.sv
// Testbench top: clock, reset, point pair stimulus, result stalls and the final verdict.
`timescale 1ns / 100ps

module testbench;

    localparam sod_pkg::t_coord C_MIN = 16'h8000;
    localparam sod_pkg::t_coord C_MAX = 16'h7FFF;
    localparam sod_pkg::t_coord C_0   = 16'h0000;

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   mismatches;
    int   pending;

    sod_in_if  pair_ch();
    sod_out_if sum_ch();

    sum_of_3d_point_distances dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pair_ch),
        .o_out   (sum_ch)
    );

    sod_distance_check sum_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (pair_ch),
        .i_out_mon    (sum_ch),
        .o_fail_count (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    // Offer one point pair after a random gap; hold it until accepted
    task automatic send_pair(input sod_pkg::t_coord ax, ay, az, bx, by, bz,
                             input sod_pkg::t_bound bnd, input bit ub, input bit lst);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_ch.ax        <= ax;
        pair_ch.ay        <= ay;
        pair_ch.az        <= az;
        pair_ch.bx        <= bx;
        pair_ch.by        <= by;
        pair_ch.bz        <= bz;
        pair_ch.bound     <= bnd;
        pair_ch.use_bound <= ub;
        pair_ch.last      <= lst;
        pair_ch.valid     <= 1'b1;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
    endtask

    // Bound spread so that some sequences are cut and others run to their end
    function automatic sod_pkg::t_bound pick_bound();
        case ($urandom_range(0, 5))
            0:       return sod_pkg::t_bound'($urandom);
            1:       return sod_pkg::t_bound'($urandom_range(0, 1000));
            2:       return sod_pkg::t_bound'($urandom_range(0, 300000));
            3:       return sod_pkg::t_bound'($urandom_range(0, 3000000));
            4:       return '1;
            default: return '0;
        endcase
    endfunction

    function automatic sod_pkg::t_coord edge_coord();
        case ($urandom_range(0, 4))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return C_0;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // Sink side: random stall per result, with quiet stretches
    initial begin : result_sink
        int stall;
        sum_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                sum_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            sum_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!sum_ch.valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        sod_pkg::t_coord qa[3];
        sod_pkg::t_coord qb[3];
        sod_pkg::t_bound seq_bound;
        sod_pkg::t_bound bnd;
        bit              seq_ub;
        bit              ub;
        bit              lst;
        int              seq_len;
        int              sent;
        int              mode;

        i_rst_n           <= 1'b0;
        pair_ch.valid     <= 1'b0;
        pair_ch.ax        <= '0;
        pair_ch.ay        <= '0;
        pair_ch.az        <= '0;
        pair_ch.bx        <= '0;
        pair_ch.by        <= '0;
        pair_ch.bz        <= '0;
        pair_ch.bound     <= '0;
        pair_ch.use_bound <= 1'b0;
        pair_ch.last      <= 1'b0;
        no_idle = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero distance, then opposite corners both ways
        send_pair(C_0, C_0, C_0, C_0, C_0, C_0, '0, 1'b0, 1'b1);
        send_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '0, 1'b0, 1'b1);
        send_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, '1, 1'b1, 1'b1);
        // Single axis extreme, then a short exact distance in the same sequence
        send_pair(C_MIN, C_0, C_0, C_MAX, C_0, C_0, '0, 1'b0, 1'b0);
        send_pair(16'd1, 16'd2, 16'd2, C_0, C_0, C_0, '0, 1'b0, 1'b1);
        // Bound exceeded on the last item; the next item starts a fresh sequence
        send_pair(16'd1, C_0, C_0, C_0, C_0, C_0, '0, 1'b1, 1'b1);
        send_pair(C_0, C_0, C_0, C_0, C_0, C_0, '0, 1'b1, 1'b1);
        // Sum equal to the bound holds; one more exceeds it before last
        send_pair(16'd3, 16'd4, C_0, C_0, C_0, C_0, 32'd5, 1'b1, 1'b0);
        send_pair(C_0, C_0, 16'd1, C_0, C_0, C_0, 32'd5, 1'b1, 1'b0);
        // Drop the rest of the cut sequence
        send_pair(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, '0, 1'b1, 1'b0);
        send_pair(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, '0, 1'b0, 1'b1);
        send_pair(16'd2, 16'd3, 16'd6, C_0, C_0, C_0, '0, 1'b0, 1'b1);
        // Floor rounding of the root
        send_pair(16'd1, 16'd1, 16'd1, C_0, C_0, C_0, '0, 1'b0, 1'b0);
        send_pair(16'hFFFE, 16'hFFFE, 16'hFFFE, C_0, C_0, C_0, '0, 1'b0, 1'b1);
        // Cut before last, then the dropped tail is a single last item
        send_pair(16'd1, C_0, C_0, C_0, C_0, C_0, '0, 1'b1, 1'b0);
        send_pair(16'd9, 16'd9, 16'd9, C_0, C_0, C_0, '0, 1'b0, 1'b1);
        send_pair(C_0, 16'd5, C_0, C_0, C_0, C_0, 32'd100, 1'b1, 1'b1);

        // Back-to-back run of maximum distances builds a large sum
        no_idle = 1'b1;
        for (int n = 0; n < 40; n++)
            send_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '1, 1'b1, n == 39);
        no_idle = 1'b0;

        // Random sequences, with some broken ones and stray flag changes
        sent = 0;
        while (sent < 1240) begin
            seq_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                    : $urandom_range(1, 8);
            no_idle   = ($urandom_range(0, 5) == 0);
            seq_ub    = ($urandom_range(0, 2) != 0);
            seq_bound = pick_bound();
            mode      = $urandom_range(0, 3);
            for (int k = 0; k < seq_len; k++) begin
                for (int ax_i = 0; ax_i < 3; ax_i++) begin
                    case (mode)
                        0: begin
                            qa[ax_i] = sod_pkg::t_coord'($urandom);
                            qb[ax_i] = sod_pkg::t_coord'($urandom);
                        end
                        1: begin
                            qa[ax_i] = edge_coord();
                            qb[ax_i] = edge_coord();
                        end
                        default: begin
                            qa[ax_i] = sod_pkg::t_coord'($urandom);
                            qb[ax_i] = qa[ax_i]
                                     + sod_pkg::t_coord'($urandom_range(0, 600))
                                     - sod_pkg::t_coord'(300);
                        end
                    endcase
                end
                lst = (k == seq_len - 1);
                if ($urandom_range(0, 19) == 0) lst = ~lst;
                ub  = seq_ub;
                if ($urandom_range(0, 9) == 0) ub = ~ub;
                bnd = ($urandom_range(0, 7) == 0) ? pick_bound() : seq_bound;
                send_pair(qa[0], qa[1], qa[2], qb[0], qb[1], qb[2], bnd, ub, lst);
                sent++;
            end
        end
        pair_ch.valid <= 1'b0;
        no_idle = 1'b0;

        // Drain outstanding sums, then allow time for anything stray to show up
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
